FILE: rtl/core/lant_pkg.sv
`timescale 1ns / 1ps

package lant_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 128;
    localparam int MAX_ANTS    = 8;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ANT_W = (MAX_ANTS > 1) ? $clog2(MAX_ANTS) : 1;

    // field and register widths
    localparam int POS_W  = 7;
    localparam int ID_W   = 3;
    localparam int SIZE_W = 8;
    localparam int CNT_W  = 4;

    localparam int GRID_WIDTH_RST  = 64;
    localparam int GRID_HEIGHT_RST = 64;
    localparam int ANT_COUNT_RST   = 1;

    typedef enum logic [1:0] {
        REQ_STEP  = 2'd0,
        REQ_PLACE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        HEAD_LEFT  = 2'd0,
        HEAD_RIGHT = 2'd1,
        HEAD_UP    = 2'd2,
        HEAD_DOWN  = 2'd3
    } t_head;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_ANT_COUNT   = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_APPLY,
        ST_FINISH
    } t_state;

    // grid memory command: row read, then masked write of one bit or a zero row
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic [COL_W-1:0] rd_col;
        logic             wr_en;
        logic             wr_clear;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        logic             wr_bit;
    } t_grid_cmd;

    function automatic t_head turn_right(input t_head hd);
        t_head r;
        unique case (hd)
            HEAD_LEFT:  r = HEAD_UP;
            HEAD_RIGHT: r = HEAD_DOWN;
            HEAD_UP:    r = HEAD_RIGHT;
            HEAD_DOWN:  r = HEAD_LEFT;
            default:    r = HEAD_LEFT;
        endcase
        return r;
    endfunction

    function automatic t_head turn_left(input t_head hd);
        t_head r;
        unique case (hd)
            HEAD_LEFT:  r = HEAD_DOWN;
            HEAD_RIGHT: r = HEAD_UP;
            HEAD_UP:    r = HEAD_LEFT;
            HEAD_DOWN:  r = HEAD_RIGHT;
            default:    r = HEAD_LEFT;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/lant_req_if.sv
`timescale 1ns / 1ps

interface lant_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [2:0] ant_index;
    logic [6:0] pos_x;
    logic [6:0] pos_y;
    logic [1:0] heading_in;

    modport source (
        output valid, req_type, ant_index, pos_x, pos_y, heading_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, ant_index, pos_x, pos_y, heading_in,
        output ready
    );
endinterface

FILE: rtl/core/lant_rsp_if.sv
`timescale 1ns / 1ps

interface lant_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] ant_id;
    logic [6:0] ant_x;
    logic [6:0] ant_y;
    logic [1:0] heading_out;
    logic       cell_value;
    logic       rejected;
    logic       last;

    modport source (
        output valid, ant_id, ant_x, ant_y, heading_out, cell_value, rejected, last,
        input  ready
    );
    modport sink (
        input  valid, ant_id, ant_x, ant_y, heading_out, cell_value, rejected, last,
        output ready
    );
endinterface

FILE: rtl/core/lant_grid.sv
`timescale 1ns / 1ps

module lant_grid (
    input  logic                  i_clk,
    input  lant_pkg::t_grid_cmd   i_cmd,
    output logic                  o_rd_bit
);

    logic [lant_pkg::MAX_COLUMNS-1:0] r_mem [lant_pkg::MAX_ROWS];
    logic [lant_pkg::MAX_COLUMNS-1:0] r_rd_row;
    logic [lant_pkg::MAX_COLUMNS-1:0] s_wr_row;

    // merge the new bit into the row fetched last
    always_comb begin
        s_wr_row = r_rd_row;
        s_wr_row[i_cmd.wr_col] = i_cmd.wr_bit;
        if (i_cmd.wr_clear) begin
            s_wr_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_row <= r_mem[i_cmd.rd_row];
        end
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_row] <= s_wr_row;
        end
    end

    assign o_rd_bit = r_rd_row[i_cmd.rd_col];

endmodule

FILE: rtl/core/langton_ant_grid_stepper_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Word
// i_req     in   valid/ready    req_type, ant_index, pos_x, pos_y, heading_in
// o_rsp     out  valid/ready    ant_id, ant_x, ant_y, heading_out, cell_value,
//                               rejected, last
// APB       in   psel/penable   grid_width @0x0, grid_height @0x4, ant_count @0x8
//
// A step visits the active ants in turn, each with a fetch on the grid row memory and an apply
// that writes the row back and emits the ant's word. Place and read pass through fetch and
// apply, rejected ones go straight to finish. Clear sweeps MAX_ROWS rows, one a cycle, then
// emits its word. After reset the same sweep runs over all rows before i_req is taken. A
// stalled o_rsp holds the sequencer in its apply or finish state; the output register frees
// the next word as soon as the current one is taken.

module langton_ant_grid_stepper_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lant_req_if.sink            i_req,
    lant_rsp_if.source          o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int ROW_W = lant_pkg::ROW_W;
    localparam int COL_W = lant_pkg::COL_W;
    localparam int ANT_W = lant_pkg::ANT_W;
    localparam int POS_W = lant_pkg::POS_W;
    localparam int SIZE_W = lant_pkg::SIZE_W;
    localparam int CNT_W = lant_pkg::CNT_W;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0] r_grid_width;
    logic [SIZE_W-1:0] r_grid_height;
    logic [CNT_W-1:0]  r_ant_count;
    logic              s_cfg_wr;

    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SIZE_W'(lant_pkg::GRID_WIDTH_RST);
            r_grid_height <= SIZE_W'(lant_pkg::GRID_HEIGHT_RST);
            r_ant_count   <= CNT_W'(lant_pkg::ANT_COUNT_RST);
        end else if (s_cfg_wr) begin
            unique case (lant_pkg::t_reg_idx'(paddr[3:2]))
                lant_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[SIZE_W-1:0];
                lant_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[SIZE_W-1:0];
                lant_pkg::REG_ANT_COUNT:   r_ant_count   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (lant_pkg::t_reg_idx'(paddr[3:2]))
            lant_pkg::REG_GRID_WIDTH:  prdata = 32'(r_grid_width);
            lant_pkg::REG_GRID_HEIGHT: prdata = 32'(r_grid_height);
            lant_pkg::REG_ANT_COUNT:   prdata = 32'(r_ant_count);
            default:                   prdata = '0;
        endcase
    end

    // effective sizes: zero acts as one, clamp to the maximum
    logic [SIZE_W-1:0] s_eff_w;
    logic [SIZE_W-1:0] s_eff_h;
    logic [CNT_W-1:0]  s_eff_n;

    always_comb begin
        s_eff_w = r_grid_width;
        if (r_grid_width == '0) s_eff_w = SIZE_W'(1);
        if (r_grid_width > SIZE_W'(lant_pkg::MAX_COLUMNS)) begin
            s_eff_w = SIZE_W'(lant_pkg::MAX_COLUMNS);
        end
        s_eff_h = r_grid_height;
        if (r_grid_height == '0) s_eff_h = SIZE_W'(1);
        if (r_grid_height > SIZE_W'(lant_pkg::MAX_ROWS)) begin
            s_eff_h = SIZE_W'(lant_pkg::MAX_ROWS);
        end
        s_eff_n = r_ant_count;
        if (r_ant_count == '0) s_eff_n = CNT_W'(1);
        if (r_ant_count > CNT_W'(lant_pkg::MAX_ANTS)) s_eff_n = CNT_W'(lant_pkg::MAX_ANTS);
    end

    // ---------------- request registers and sequencer state ----------------
    lant_pkg::t_state  r_state, n_state;
    logic [ROW_W-1:0]  r_row_cnt;
    lant_pkg::t_req    r_req;
    logic [2:0]        r_idx;
    logic [POS_W-1:0]  r_px;
    logic [POS_W-1:0]  r_py;
    lant_pkg::t_head   r_hin;
    logic              r_rej;
    logic [ANT_W-1:0]  r_ant;

    // ant table: one entry read per cycle, at r_ant
    logic [POS_W-1:0]  r_ant_x  [lant_pkg::MAX_ANTS];
    logic [POS_W-1:0]  r_ant_y  [lant_pkg::MAX_ANTS];
    lant_pkg::t_head   r_ant_hd [lant_pkg::MAX_ANTS];

    // output register
    logic              r_out_valid;
    logic [2:0]        r_out_id;
    logic [POS_W-1:0]  r_out_x;
    logic [POS_W-1:0]  r_out_y;
    logic [1:0]        r_out_hd;
    logic              r_out_cell;
    logic              r_out_rej;
    logic              r_out_last;

    // ---------------- datapath ----------------
    lant_pkg::t_grid_cmd s_cmd;
    logic              s_rd_bit;
    logic              s_in_acc;
    logic              s_in_rej;
    logic              s_out_free;
    logic              s_load;
    logic              s_last_row;
    logic              s_last_ant;
    logic [POS_W-1:0]  s_cur_x;
    logic [POS_W-1:0]  s_cur_y;
    lant_pkg::t_head   s_cur_hd;
    lant_pkg::t_head   s_new_hd;
    logic [SIZE_W-1:0] s_mx;
    logic [SIZE_W-1:0] s_my;
    logic [POS_W-1:0]  s_nx;
    logic [POS_W-1:0]  s_ny;
    logic [POS_W-1:0]  s_ctr_x;
    logic [POS_W-1:0]  s_ctr_y;

    // result word built in apply or finish
    logic [2:0]        s_res_id;
    logic [POS_W-1:0]  s_res_x;
    logic [POS_W-1:0]  s_res_y;
    logic [1:0]        s_res_hd;
    logic              s_res_cell;
    logic              s_res_rej;
    logic              s_res_last;

    lant_grid u_grid (
        .i_clk    (i_clk),
        .i_cmd    (s_cmd),
        .o_rd_bit (s_rd_bit)
    );

    assign s_in_acc   = i_req.valid && i_req.ready;
    assign s_out_free = !r_out_valid || o_rsp.ready;
    assign s_last_row = (r_row_cnt == ROW_W'(lant_pkg::MAX_ROWS - 1));
    assign s_last_ant = ((CNT_W'(r_ant) + CNT_W'(1)) == s_eff_n);

    assign s_cur_x  = r_ant_x[r_ant];
    assign s_cur_y  = r_ant_y[r_ant];
    assign s_cur_hd = r_ant_hd[r_ant];

    assign s_ctr_x = POS_W'(s_eff_w >> 1);
    assign s_ctr_y = POS_W'(s_eff_h >> 1);

    // place and read coordinates checked against the live size; step and clear never reject
    always_comb begin
        s_in_rej = (SIZE_W'(i_req.pos_x) >= s_eff_w) || (SIZE_W'(i_req.pos_y) >= s_eff_h);
        if (lant_pkg::t_req'(i_req.req_type) == lant_pkg::REQ_PLACE &&
            SIZE_W'(i_req.ant_index) >= SIZE_W'(lant_pkg::MAX_ANTS)) begin
            s_in_rej = 1'b1;
        end
        if (lant_pkg::t_req'(i_req.req_type) == lant_pkg::REQ_STEP ||
            lant_pkg::t_req'(i_req.req_type) == lant_pkg::REQ_CLEAR) begin
            s_in_rej = 1'b0;
        end
    end

    // turn on the fetched cell, then advance one cell with toroidal wrap
    always_comb begin
        s_new_hd = s_rd_bit ? lant_pkg::turn_left(s_cur_hd) : lant_pkg::turn_right(s_cur_hd);
        s_mx = SIZE_W'(s_cur_x);
        s_my = SIZE_W'(s_cur_y);
        case (s_new_hd)
            lant_pkg::HEAD_LEFT:  s_mx = (s_cur_x == '0) ? s_eff_w - SIZE_W'(1)
                                                          : SIZE_W'(s_cur_x) - SIZE_W'(1);
            lant_pkg::HEAD_RIGHT: s_mx = SIZE_W'(s_cur_x) + SIZE_W'(1);
            lant_pkg::HEAD_UP:    s_my = (s_cur_y == '0) ? s_eff_h - SIZE_W'(1)
                                                          : SIZE_W'(s_cur_y) - SIZE_W'(1);
            default:              s_my = SIZE_W'(s_cur_y) + SIZE_W'(1);
        endcase
        s_nx = (s_mx >= s_eff_w) ? '0 : s_mx[POS_W-1:0];
        s_ny = (s_my >= s_eff_h) ? '0 : s_my[POS_W-1:0];
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lant_pkg::ST_INIT: begin
                if (s_last_row) n_state = lant_pkg::ST_IDLE;
            end
            lant_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    case (lant_pkg::t_req'(i_req.req_type))
                        lant_pkg::REQ_STEP:  n_state = lant_pkg::ST_FETCH;
                        lant_pkg::REQ_CLEAR: n_state = lant_pkg::ST_CLEAR;
                        default: n_state = s_in_rej ? lant_pkg::ST_FINISH : lant_pkg::ST_FETCH;
                    endcase
                end
            end
            lant_pkg::ST_CLEAR: begin
                if (s_last_row) n_state = lant_pkg::ST_FINISH;
            end
            lant_pkg::ST_FETCH: begin
                n_state = lant_pkg::ST_APPLY;
            end
            lant_pkg::ST_APPLY: begin
                if (s_out_free) begin
                    if (r_req == lant_pkg::REQ_STEP && !s_last_ant) begin
                        n_state = lant_pkg::ST_FETCH;
                    end else begin
                        n_state = lant_pkg::ST_IDLE;
                    end
                end
            end
            lant_pkg::ST_FINISH: begin
                if (s_out_free) n_state = lant_pkg::ST_IDLE;
            end
            default: n_state = lant_pkg::ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        s_cmd       = '0;
        s_cmd.rd_col = (r_req == lant_pkg::REQ_STEP) ? COL_W'(s_cur_x) : COL_W'(r_px);
        i_req.ready = 1'b0;
        s_load      = 1'b0;
        s_res_id    = '0;
        s_res_x     = '0;
        s_res_y     = '0;
        s_res_hd    = '0;
        s_res_cell  = 1'b0;
        s_res_rej   = 1'b0;
        s_res_last  = 1'b1;
        unique case (r_state)
            lant_pkg::ST_INIT, lant_pkg::ST_CLEAR: begin
                s_cmd.wr_en    = 1'b1;
                s_cmd.wr_clear = 1'b1;
                s_cmd.wr_row   = r_row_cnt;
            end
            lant_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            lant_pkg::ST_FETCH: begin
                s_cmd.rd_en  = 1'b1;
                s_cmd.rd_row = (r_req == lant_pkg::REQ_STEP) ? ROW_W'(s_cur_y) : ROW_W'(r_py);
            end
            lant_pkg::ST_APPLY: begin
                s_load = s_out_free;
                case (r_req)
                    lant_pkg::REQ_STEP: begin
                        s_cmd.wr_en  = s_out_free;
                        s_cmd.wr_row = ROW_W'(s_cur_y);
                        s_cmd.wr_col = COL_W'(s_cur_x);
                        s_cmd.wr_bit = !s_rd_bit;
                        s_res_id     = 3'(r_ant);
                        s_res_x      = s_nx;
                        s_res_y      = s_ny;
                        s_res_hd     = s_new_hd;
                        s_res_cell   = !s_rd_bit;
                        s_res_last   = s_last_ant;
                    end
                    lant_pkg::REQ_PLACE: begin
                        s_res_id   = r_idx;
                        s_res_x    = r_px;
                        s_res_y    = r_py;
                        s_res_hd   = r_hin;
                        s_res_cell = s_rd_bit;
                    end
                    default: begin
                        s_res_x    = r_px;
                        s_res_y    = r_py;
                        s_res_cell = s_rd_bit;
                    end
                endcase
            end
            lant_pkg::ST_FINISH: begin
                s_load    = s_out_free;
                s_res_rej = r_rej;
                case (r_req)
                    lant_pkg::REQ_CLEAR: begin
                        s_res_x  = s_ctr_x;
                        s_res_y  = s_ctr_y;
                        s_res_hd = lant_pkg::HEAD_LEFT;
                    end
                    lant_pkg::REQ_PLACE: begin
                        s_res_id = r_idx;
                    end
                    default: begin
                        s_res_x = r_px;
                        s_res_y = r_py;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // ---------------- sequencer registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lant_pkg::ST_INIT;
            r_row_cnt <= '0;
            r_ant     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lant_pkg::ST_INIT || r_state == lant_pkg::ST_CLEAR) begin
                r_row_cnt <= r_row_cnt + ROW_W'(1);
            end
            if (s_in_acc) begin
                r_row_cnt <= '0;
                r_ant     <= '0;
            end else if (r_state == lant_pkg::ST_APPLY && s_load) begin
                r_ant <= r_ant + ANT_W'(1);
            end
        end
    end

    // hold the accepted word
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_req <= lant_pkg::t_req'(i_req.req_type);
            r_idx <= i_req.ant_index;
            r_px  <= i_req.pos_x;
            r_py  <= i_req.pos_y;
            r_hin <= lant_pkg::t_head'(i_req.heading_in);
            r_rej <= s_in_rej;
        end
    end

    // ant table updates: step moves the current ant, place writes the chosen
    // ant, clear re-centers ant 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lant_pkg::MAX_ANTS; i++) begin
                r_ant_x[i]  <= (i == 0) ? POS_W'(lant_pkg::GRID_WIDTH_RST / 2) : '0;
                r_ant_y[i]  <= (i == 0) ? POS_W'(lant_pkg::GRID_HEIGHT_RST / 2) : '0;
                r_ant_hd[i] <= lant_pkg::HEAD_LEFT;
            end
        end else if (s_load) begin
            if (r_state == lant_pkg::ST_APPLY && r_req == lant_pkg::REQ_STEP) begin
                r_ant_x[r_ant]  <= s_nx;
                r_ant_y[r_ant]  <= s_ny;
                r_ant_hd[r_ant] <= s_new_hd;
            end else if (r_state == lant_pkg::ST_APPLY && r_req == lant_pkg::REQ_PLACE) begin
                r_ant_x[ANT_W'(r_idx)]  <= r_px;
                r_ant_y[ANT_W'(r_idx)]  <= r_py;
                r_ant_hd[ANT_W'(r_idx)] <= r_hin;
            end else if (r_state == lant_pkg::ST_FINISH && r_req == lant_pkg::REQ_CLEAR) begin
                r_ant_x[0]  <= s_ctr_x;
                r_ant_y[0]  <= s_ctr_y;
                r_ant_hd[0] <= lant_pkg::HEAD_LEFT;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out_id   <= s_res_id;
            r_out_x    <= s_res_x;
            r_out_y    <= s_res_y;
            r_out_hd   <= s_res_hd;
            r_out_cell <= s_res_cell;
            r_out_rej  <= s_res_rej;
            r_out_last <= s_res_last;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ant_id      = r_out_id;
    assign o_rsp.ant_x       = r_out_x;
    assign o_rsp.ant_y       = r_out_y;
    assign o_rsp.heading_out = r_out_hd;
    assign o_rsp.cell_value  = r_out_cell;
    assign o_rsp.rejected    = r_out_rej;
    assign o_rsp.last        = r_out_last;

endmodule
